@@ design/iterative_global_threshold_unit_assert.svh @@
// Assertion macros used by the top-level design file.
`ifndef ITERATIVE_GLOBAL_THRESHOLD_UNIT_ASSERT_SVH
`define ITERATIVE_GLOBAL_THRESHOLD_UNIT_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define IGT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define IGT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/igt_pkg.sv @@
package igt_pkg;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LAST, S_MEAN, S_LOOP, S_SWEEP,
    S_DRAIN, S_CHK, S_DIV1, S_DIV2, S_UPD, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    RES_CONV, RES_EMPTY, RES_CAP, RES_OVF
  } res_t;

  typedef enum logic [1:0] {
    DSEL_MEAN, DSEL_G1, DSEL_G2
  } dsel_t;

  localparam logic REG_TOL   = 1'b0;
  localparam logic REG_MAXIT = 1'b1;

  typedef struct packed {
    logic  acc;
    logic  clr_wr;
    logic  idx_rst;
    logic  idx_inc;
    logic  sw_rd;
    logic  acc_rst;
    logic  div_start;
    dsel_t dsel;
    logic  ld_t;
    logic  ld_m1;
    logic  upd;
    logic  pass_rst;
    logic  emit;
    res_t  code;
    logic  img_clr;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic div_done;
    logic ovf;
    logic sw_busy;
    logic empty;
    logic conv;
    logic cap;
  } sts_t;

endpackage

@@ design/igt_div.sv @@
module igt_div #(
  parameter int NW = 41,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [15:0]   quo
);
  // Restoring division, one quotient bit a cycle; the quotient is known to fit 16 bits.
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [3:0]    step_r, step_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] d_r, d_nxt;
  logic [15:0]   q_r, q_nxt;
  logic          ge;

  assign ge = rem_r >= d_r;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = 4'd15;
      rem_nxt  = num;
      d_nxt    = NW'(den) << 15;
      q_nxt    = 16'd0;
    end else if (run_r) begin
      rem_nxt  = ge ? rem_r - d_r : rem_r;
      q_nxt    = {q_r[14:0], ge};
      d_nxt    = d_r >> 1;
      step_nxt = step_r - 4'd1;
      if (step_r == 4'd0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= 4'd0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

@@ design/igt_ctrl.sv @@
module igt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_last,
  input  igt_pkg::sts_t sts,
  output igt_pkg::cmd_t cmd,
  output logic          busy
);
  import igt_pkg::*;

  state_t st_r, st_nxt;
  res_t   code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_CLEAR;
      code_r <= RES_CONV;
    end else begin
      st_r   <= st_nxt;
      code_r <= code_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    code_nxt = code_r;
    cmd      = '0;
    cmd.dsel = DSEL_MEAN;
    cmd.code = code_r;
    busy     = 1'b1;
    unique case (st_r)
      S_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        busy    = 1'b0;
        cmd.acc = start;
        if (start && in_last) st_nxt = S_LAST;
      end
      S_LAST: begin
        // This cycle also lets the last histogram write land before any sweep.
        if (sts.ovf) begin
          code_nxt = RES_OVF;
          st_nxt   = S_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.pass_rst  = 1'b1;
          st_nxt        = S_MEAN;
        end
      end
      S_MEAN: begin
        if (sts.div_done) begin
          cmd.ld_t = 1'b1;
          st_nxt   = S_LOOP;
        end
      end
      S_LOOP: begin
        if (sts.cap) begin
          code_nxt = RES_CAP;
          st_nxt   = S_EMIT;
        end else begin
          cmd.idx_rst = 1'b1;
          cmd.acc_rst = 1'b1;
          st_nxt      = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.sw_rd   = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last) st_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.sw_busy) st_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.empty) begin
          code_nxt = RES_EMPTY;
          st_nxt   = S_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.dsel      = DSEL_G1;
          st_nxt        = S_DIV1;
        end
      end
      S_DIV1: begin
        if (sts.div_done) begin
          cmd.ld_m1     = 1'b1;
          cmd.div_start = 1'b1;
          cmd.dsel      = DSEL_G2;
          st_nxt        = S_DIV2;
        end
      end
      S_DIV2: begin
        if (sts.div_done) st_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (sts.conv) begin
          code_nxt = RES_CONV;
          st_nxt   = S_EMIT;
        end else begin
          st_nxt = S_LOOP;
        end
      end
      S_EMIT: begin
        cmd.emit    = 1'b1;
        cmd.img_clr = 1'b1;
        cmd.idx_rst = 1'b1;
        st_nxt      = S_CLEAR;
      end
      default: st_nxt = S_CLEAR;
    endcase
  end
endmodule

@@ design/igt_dp.sv @@
module igt_dp #(
  parameter int MAX_PIXELS = 65536
) (
  input  logic          clk,
  input  logic          rst_n,
  input  igt_pkg::cmd_t cmd,
  output igt_pkg::sts_t sts,
  input  logic [7:0]    in_pixel,
  input  logic [15:0]   tol,
  input  logic [7:0]    max_iter,
  output logic          out_valid,
  output logic [15:0]   out_threshold,
  output logic [7:0]    out_iterations,
  output logic [1:0]    out_status
);
  import igt_pkg::*;

  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int SW = $clog2(longint'(255) * longint'(MAX_PIXELS) + longint'(1));
  localparam int NW = SW + 9;
  localparam int PW = CW + 8;

  logic [CW-1:0] hist_mem [256];
  logic [CW-1:0] rd_r;
  logic [7:0]    rd_addr;
  logic [7:0]    idx_r;

  logic [CW-1:0] cnt_r;
  logic [SW-1:0] sum_r;
  logic          ovf_r;

  logic          pw_v_r, fw_v_r;
  logic [7:0]    pw_a_r, fw_a_r;
  logic [CW-1:0] fw_d_r, base, wval;

  logic          rdv_r, pv_r, pg_r;
  logic [7:0]    rv_r;
  logic [SW-1:0] p_r;
  logic [CW-1:0] pc_r;
  logic [PW-1:0] prod;
  logic [SW-1:0] s1_r, s2_r;
  logic [CW-1:0] c1_r, c2_r;

  logic [15:0]   t_r, m1_r, nt, diff;
  logic [16:0]   tsum;
  logic [7:0]    passes_r;

  logic [SW-1:0] dsum;
  logic [CW-1:0] dcnt;
  logic [NW-1:0] dnum;
  logic          div_done;
  logic [15:0]   quo;

  logic          ov_r;
  logic [15:0]   oth_r;
  logic [7:0]    oit_r;
  logic [1:0]    ost_r;

  assign rd_addr = cmd.acc ? in_pixel : idx_r;
  // A bin written in the previous cycle was read stale, so its new count is forwarded.
  assign base = (fw_v_r && fw_a_r == pw_a_r) ? fw_d_r : rd_r;
  assign wval = base + CW'(1);

  always_ff @(posedge clk) begin
    rd_r <= hist_mem[rd_addr];
    if (cmd.clr_wr) hist_mem[idx_r] <= '0;
    else if (pw_v_r) hist_mem[pw_a_r] <= wval;
  end

  assign prod = PW'(rv_r) * PW'(rd_r);

  always_comb begin
    unique case (cmd.dsel)
      DSEL_MEAN: begin dsum = sum_r; dcnt = cnt_r; end
      DSEL_G1:   begin dsum = s1_r;  dcnt = c1_r;  end
      DSEL_G2:   begin dsum = s2_r;  dcnt = c2_r;  end
      default:   begin dsum = sum_r; dcnt = cnt_r; end
    endcase
  end
  assign dnum = (NW'(dsum) << 8) + NW'(dcnt >> 1);

  igt_div #(.NW(NW), .DW(CW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (dnum),
    .den   (dcnt),
    .done  (div_done),
    .quo   (quo)
  );

  assign tsum = 17'(m1_r) + 17'(quo) + 17'd1;
  assign nt   = tsum[16:1];
  assign diff = (nt > t_r) ? nt - t_r : t_r - nt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= 8'd0;
      cnt_r    <= '0;
      sum_r    <= '0;
      ovf_r    <= 1'b0;
      pw_v_r   <= 1'b0;
      fw_v_r   <= 1'b0;
      rdv_r    <= 1'b0;
      pv_r     <= 1'b0;
      passes_r <= 8'd0;
      ov_r     <= 1'b0;
    end else begin
      if (cmd.idx_rst) idx_r <= 8'd0;
      else if (cmd.idx_inc) idx_r <= idx_r + 8'd1;

      pw_v_r <= 1'b0;
      if (cmd.img_clr) begin
        cnt_r <= '0;
        sum_r <= '0;
        ovf_r <= 1'b0;
      end else if (cmd.acc) begin
        if (cnt_r < CW'(MAX_PIXELS)) begin
          cnt_r  <= cnt_r + CW'(1);
          sum_r  <= sum_r + SW'(in_pixel);
          pw_v_r <= 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      fw_v_r <= pw_v_r;

      rdv_r <= cmd.sw_rd;
      pv_r  <= rdv_r;

      if (cmd.pass_rst) passes_r <= 8'd0;
      else if (cmd.upd) passes_r <= passes_r + 8'd1;

      ov_r <= cmd.emit;
    end
    pw_a_r <= in_pixel;
    fw_a_r <= pw_a_r;
    fw_d_r <= wval;
    rv_r   <= idx_r;
    p_r    <= SW'(prod);
    pc_r   <= rd_r;
    pg_r   <= {rv_r, 8'd0} < t_r;

    if (cmd.acc_rst) begin
      s1_r <= '0; c1_r <= '0; s2_r <= '0; c2_r <= '0;
    end else if (pv_r) begin
      if (pg_r) begin
        s1_r <= s1_r + p_r;
        c1_r <= c1_r + pc_r;
      end else begin
        s2_r <= s2_r + p_r;
        c2_r <= c2_r + pc_r;
      end
    end

    if (cmd.ld_t) t_r <= quo;
    else if (cmd.upd) t_r <= nt;
    if (cmd.ld_m1) m1_r <= quo;

    if (cmd.emit) begin
      oth_r <= (cmd.code == RES_OVF) ? 16'd0 : t_r;
      oit_r <= (cmd.code == RES_OVF) ? 8'd0 : passes_r;
      ost_r <= cmd.code;
    end
  end

  always_comb begin
    sts.idx_last = idx_r == 8'hFF;
    sts.div_done = div_done;
    sts.ovf      = ovf_r;
    sts.sw_busy  = rdv_r | pv_r;
    sts.empty    = (c1_r == '0) || (c2_r == '0);
    sts.conv     = diff < tol;
    sts.cap      = passes_r == max_iter;
  end

  assign out_valid      = ov_r;
  assign out_threshold  = oth_r;
  assign out_iterations = oit_r;
  assign out_status     = ost_r;
endmodule

@@ design/iterative_global_threshold_unit.sv @@
// Pixels are taken one a cycle while busy is low; the last pixel raises busy.
// After the last pixel, a serial division first gives the mean; each refinement pass then
// sweeps the whole histogram and runs two serial divisions, one for each class mean.
// The result word is shown for one cycle, as a clear of the whole histogram begins.
// Synchronous reset also runs the histogram clear with busy high; results cannot be stalled.
module iterative_global_threshold_unit #(
  parameter int MAX_PIXELS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_pixel,
  input  logic        in_last,
  output logic        out_valid,
  output logic [15:0] out_threshold,
  output logic [7:0]  out_iterations,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import igt_pkg::*;
  `include "iterative_global_threshold_unit_assert.svh"

  cmd_t        cmd;
  sts_t        sts;
  logic [15:0] tol_r;
  logic [7:0]  maxit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= 16'd52;
      maxit_r <= 8'd64;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_TOL) tol_r <= pwdata[15:0];
      else maxit_r <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAXIT) ? {24'd0, maxit_r} : {16'd0, tol_r};

  igt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_last),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  igt_dp #(.MAX_PIXELS(MAX_PIXELS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_pixel       (in_pixel),
    .tol            (tol_r),
    .max_iter       (maxit_r),
    .out_valid      (out_valid),
    .out_threshold  (out_threshold),
    .out_iterations (out_iterations),
    .out_status     (out_status)
  );

  `IGT_ASSERT_NEXT(a_last_busy, start && !busy && in_last, busy, "no busy after last pixel")
  `IGT_ASSERT_SAME(a_out_busy, out_valid, busy, "result word while idle")
  `IGT_ASSERT_SAME(a_conv_iter, out_valid && out_status == RES_CONV, out_iterations != 8'd0, "converged with no pass")
  `IGT_ASSERT_SAME(a_ovf_zero, out_valid && out_status == RES_OVF, out_threshold == 16'd0 && out_iterations == 8'd0, "overflow word not zero")
endmodule
